// ===== rtl/shvt_pkg.sv =====
package shvt_pkg;

    // default sizing for the top-level parameters
    localparam int SLOT_COUNT_DEF = 256;
    localparam int VALUE_BITS_DEF = 32;

    // fixed field and register widths
    localparam int HASH_BITS       = 64;
    localparam int TABLE_SIZE_BITS = 9;
    localparam int KEY_BITS        = 8;
    localparam int WORD_BITS       = 32;
    localparam int SLOT_OUT_BITS   = 8;

    localparam logic [TABLE_SIZE_BITS-1:0] TABLE_SIZE_RESET = 9'd256;

    // request and completion codes
    localparam logic [1:0] REQ_GET  = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_FILL = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [KEY_BITS-1:0]  key_byte;
        logic                 key_last;
        logic [WORD_BITS-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0]     read_value;
        logic [SLOT_OUT_BITS-1:0] slot_index;
        logic [1:0]               done_kind;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic div_step;
        logic ram_en;
        logic ram_we;
        logic sweep_en;
        logic sweep_clear;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] in_kind;
        logic       in_last;
        logic [1:0] kind;
        logic       div_last;
        logic       sweep_last;
    } dp_status_t;

endpackage

// ===== rtl/shvt_ram.sv =====
module shvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read, read data holds between reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/shvt_datapath.sv =====
module shvt_datapath #(
    parameter int SLOT_COUNT = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  shvt_pkg::req_t                           req_data,
    input  logic                                     cfg_valid,
    input  logic [shvt_pkg::TABLE_SIZE_BITS-1:0]     cfg_data,
    input  shvt_pkg::ctrl_cmd_t                      cmd,
    output shvt_pkg::dp_status_t                     status,
    output shvt_pkg::rsp_t                           rsp_data
);
    import shvt_pkg::*;

    localparam int ADDR_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CMP_W    = (ADDR_W > TABLE_SIZE_BITS) ? ADDR_W : TABLE_SIZE_BITS;
    localparam int SIZE_MAX = (1 << TABLE_SIZE_BITS) - 1;
    localparam int SIZE_CAP = (SLOT_COUNT < SIZE_MAX) ? SLOT_COUNT : SIZE_MAX;
    localparam int CNT_W    = $clog2(HASH_BITS);

    logic [HASH_BITS-1:0]       hash_reg, hash_next, hash_upd;
    logic [TABLE_SIZE_BITS-1:0] size_reg;
    logic [TABLE_SIZE_BITS-1:0] n_eff;
    logic [ADDR_W-1:0]          sweep_reg, sweep_next;
    logic [HASH_BITS-1:0]       dvd_reg, dvd_next;
    logic [TABLE_SIZE_BITS-1:0] rem_reg, rem_next;
    logic [TABLE_SIZE_BITS:0]   rem_trial;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [VALUE_BITS-1:0]      wval_reg, wval_next;
    rsp_t                       rsp_reg, rsp_next;
    logic [ADDR_W-1:0]          ram_addr;
    logic [VALUE_BITS-1:0]      ram_wdata;
    logic [VALUE_BITS-1:0]      ram_rdata;

    // effective table size, zero acts as one, clamp to the store depth and to 511
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = TABLE_SIZE_BITS'(1);
        end
        else if (size_reg > TABLE_SIZE_BITS'(SIZE_CAP))
        begin
            n_eff = TABLE_SIZE_BITS'(SIZE_CAP);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    // hash * 97 + byte, with 97 = 64 + 32 + 1, zero byte not mixed in
    always_comb
    begin
        if (req_data.key_byte != '0)
        begin
            hash_upd = (hash_reg << 6) + (hash_reg << 5) + hash_reg
                     + HASH_BITS'(req_data.key_byte);
        end
        else
        begin
            hash_upd = hash_reg;
        end
    end

    // one restoring remainder step per cycle
    assign rem_trial = {rem_reg, dvd_reg[HASH_BITS-1]};

    always_comb
    begin
        hash_next = hash_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        kind_next = kind_reg;
        wval_next = wval_reg;
        if (cmd.accept)
        begin
            kind_next = req_data.req_type;
            wval_next = VALUE_BITS'(req_data.write_value);
            case (req_data.req_type) inside
                REQ_GET, REQ_SET:
                begin
                    if (req_data.key_last)
                    begin
                        hash_next = '0;
                        dvd_next  = hash_upd;
                        rem_next  = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        hash_next = hash_upd;
                    end
                end
                REQ_FILL:
                begin
                    hash_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.div_step)
        begin
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (rem_trial >= {1'b0, n_eff})
            begin
                rem_next = TABLE_SIZE_BITS'(rem_trial - {1'b0, n_eff});
            end
            else
            begin
                rem_next = TABLE_SIZE_BITS'(rem_trial);
            end
        end
    end

    // sweep counter for the reset clear and the fill
    assign sweep_next = cmd.sweep_en ? (sweep_reg + ADDR_W'(1)) : '0;

    assign status.sweep_last = cmd.sweep_clear
                             ? (sweep_reg == ADDR_W'(SLOT_COUNT - 1))
                             : (CMP_W'(sweep_reg) == CMP_W'(n_eff - TABLE_SIZE_BITS'(1)));

    assign status.in_kind  = req_data.req_type;
    assign status.in_last  = req_data.key_last;
    assign status.kind     = kind_reg;
    assign status.div_last = (cnt_reg == CNT_W'(HASH_BITS - 1));

    // slot store
    assign ram_addr  = cmd.sweep_en ? sweep_reg : ADDR_W'(rem_reg);
    assign ram_wdata = cmd.sweep_clear ? '0 : wval_reg;

    shvt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .clk   (clk),
        .en    (cmd.ram_en),
        .we    (cmd.ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // result beat
    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.load_out)
        begin
            rsp_next.done_kind  = kind_reg;
            rsp_next.slot_index = (kind_reg == REQ_FILL) ? '0 : SLOT_OUT_BITS'(rem_reg);
            rsp_next.read_value = (kind_reg == REQ_GET) ? WORD_BITS'(ram_rdata) : '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            size_reg  <= TABLE_SIZE_RESET;
            sweep_reg <= '0;
        end
        else
        begin
            hash_reg  <= hash_next;
            sweep_reg <= sweep_next;
            if (cfg_valid)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        kind_reg <= kind_next;
        wval_reg <= wval_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_data = rsp_reg;

`ifndef SYNTHESIS
    // a set writes inside the table in use
    a_set_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ram_we && !cmd.sweep_en) |-> (rem_reg < n_eff))
        else $error("set slot outside table size");

    // fill sweep stays below the table size
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_en && !cmd.sweep_clear) |-> (CMP_W'(sweep_reg) < CMP_W'(n_eff)))
        else $error("fill sweep beyond table size");
`endif

endmodule

// ===== rtl/shvt_ctrl.sv =====
module shvt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    input  shvt_pkg::dp_status_t status,
    output shvt_pkg::ctrl_cmd_t  cmd
);
    import shvt_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ACCESS,
        S_FILL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // next state and datapath commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_en    = 1'b1;
                cmd.sweep_clear = 1'b1;
                cmd.ram_en      = 1'b1;
                cmd.ram_we      = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (status.in_kind) inside
                        REQ_GET, REQ_SET:
                        begin
                            if (status.in_last)
                            begin
                                state_next = S_DIV;
                            end
                        end
                        REQ_FILL:
                        begin
                            state_next = S_FILL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_ACCESS;
                end
            end
            S_ACCESS:
            begin
                cmd.ram_en = 1'b1;
                cmd.ram_we = (status.kind == REQ_SET);
                state_next = S_DONE;
            end
            S_FILL:
            begin
                cmd.sweep_en = 1'b1;
                cmd.ram_en   = 1'b1;
                cmd.ram_we   = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    // never overwrite a result beat still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(rsp_valid_reg && rsp_stall))
        else $error("result beat overwritten");

    // an accepted fill goes straight to the sweep
    a_fill_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && status.in_kind == REQ_FILL)
        |=> (state_reg == S_FILL))
        else $error("fill did not start");

    // a result beat only appears after the done state
    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result beat out of sequence");
`endif

endmodule

// ===== rtl/string_hash_value_table.sv =====
// non-final key byte: taken in one cycle, no result beat
// final key byte (get/set): taken, then 64 remainder steps, one store access and the result load
// fill: taken, then one store write per slot of the table size, then the result load; one item in flight
// a finished beat may wait in the output register while the next key bytes are taken
// rst_n asynchronous active low; afterwards a clearing pass over all SLOT_COUNT slots zeroes the store
module string_hash_value_table #(
    parameter int SLOT_COUNT = shvt_pkg::SLOT_COUNT_DEF,
    parameter int VALUE_BITS = shvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  shvt_pkg::req_t                       req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output shvt_pkg::rsp_t                       rsp_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [shvt_pkg::TABLE_SIZE_BITS-1:0] cfg_data
);
    import shvt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // table size register always takes a write
    assign cfg_ready = 1'b1;

    shvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    shvt_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_data  (rsp_data)
    );

endmodule
